[rtl/rcpm_pkg.sv]
// Package with shared types and constants for the column pixel mapper.
`timescale 1ns / 1ps
`default_nettype none
package rcpm_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS = 12;
  localparam int NUM_W = 45;
  localparam int DVS_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT  = 4'd0,
    REG_FRAME_STRIDE  = 4'd1,
    REG_FRAME_BPP     = 4'd2,
    REG_TEXTURE_STRIDE = 4'd3,
    REG_TEXTURE_HEIGHT = 4'd4,
    REG_TEXTURE_BPP   = 4'd5,
    REG_CEILING_COLOR = 4'd6,
    REG_FLOOR_COLOR   = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_CEILING = 3'd0,
    KIND_TEXEL   = 3'd1,
    KIND_FLOOR   = 3'd2,
    KIND_INVALID = 3'd3,
    KIND_NONE    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [11:0] column_x;
    logic [10:0] row_y;
    logic [10:0] span_start;
    logic [10:0] span_end;
    logic [15:0] wall_height;
    logic [11:0] texture_column;
  } in_t;

  typedef struct packed {
    logic [2:0]  pixel_kind;
    logic [24:0] dest_offset;
    logic [23:0] fill_color;
    logic [25:0] texel_offset;
    logic [11:0] texture_row;
    logic        row_clamped;
  } out_t;

  typedef struct packed {
    logic [11:0] frame_height;
    logic [14:0] frame_stride;
    logic [5:0]  frame_bpp;
    logic [14:0] texture_stride;
    logic [12:0] texture_height;
    logic [5:0]  texture_bpp;
    logic [23:0] ceiling_color;
    logic [23:0] floor_color;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [24:0] dest;
    logic [23:0] fill;
    logic [11:0] tcol;
  } side_t;

endpackage
`default_nettype wire

[rtl/rcpm_front.sv]
// Front stages: classification, products, signed row offset and numerator.
`timescale 1ns / 1ps
`default_nettype none
module rcpm_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire rcpm_pkg::in_t        in_item,
  input  wire rcpm_pkg::cfg_t       cfg,
  output logic                      out_valid,
  output rcpm_pkg::side_t           out_side,
  output logic [rcpm_pkg::NUM_W-1:0] out_num,
  output logic                      out_neg,
  output logic [rcpm_pkg::DVS_W-1:0] out_dvs
);
  import rcpm_pkg::*;

  logic        v1_r, v2_r, v3_r;
  side_t       side1_r, side2_r, side3_r, side1_nxt;
  logic [25:0] yt1_r;
  logic [26:0] ft1_r;
  logic [30:0] lt1_r, lt2_r, lt3_r;
  logic [25:0] yfs1_r;
  logic [17:0] xb1_r;
  logic [31:0] mag2_r, mag2_nxt;
  logic        neg2_r, neg3_r;
  logic [24:0] dest2_nxt;
  logic [32:0] d_sum;
  logic [NUM_W-1:0] num3_r;

  always_comb begin
    side1_nxt.dest = '0;
    side1_nxt.fill = '0;
    side1_nxt.tcol = in_item.texture_column;
    if (in_item.row_y >= in_item.span_start && in_item.row_y <= in_item.span_end) begin
      side1_nxt.kind = (in_item.wall_height == 16'd0) ? KIND_INVALID : KIND_TEXEL;
    end else if (in_item.row_y > in_item.span_end &&
                 {1'b0, in_item.row_y} < cfg.frame_height) begin
      side1_nxt.kind = KIND_FLOOR;
      side1_nxt.fill = cfg.floor_color;
    end else if (in_item.row_y < in_item.span_start) begin
      side1_nxt.kind = KIND_CEILING;
      side1_nxt.fill = cfg.ceiling_color;
    end else begin
      side1_nxt.kind = KIND_NONE;
    end
  end

  always_comb begin
    d_sum = {7'd0, yt1_r} - {7'd0, ft1_r[26:1]} + {3'd0, lt1_r[30:1]};
    mag2_nxt = d_sum[32] ? 32'(-d_sum) : d_sum[31:0];
    dest2_nxt = 25'(yfs1_r + {11'd0, xb1_r[17:3]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= side1_nxt;
    yt1_r   <= 26'(in_item.row_y * cfg.texture_stride);
    ft1_r   <= 27'(cfg.frame_height * cfg.texture_stride);
    lt1_r   <= 31'(in_item.wall_height * cfg.texture_stride);
    yfs1_r  <= 26'(in_item.row_y * cfg.frame_stride);
    xb1_r   <= 18'(in_item.column_x * cfg.frame_bpp);

    side2_r      <= '{kind: side1_r.kind, dest: dest2_nxt, fill: side1_r.fill,
                      tcol: side1_r.tcol};
    mag2_r       <= mag2_nxt;
    neg2_r       <= d_sum[32];
    lt2_r        <= lt1_r;

    side3_r <= side2_r;
    num3_r  <= NUM_W'(mag2_r * cfg.texture_height);
    neg3_r  <= neg2_r;
    lt3_r   <= lt2_r;
  end

  assign out_valid = v3_r;
  assign out_side  = side3_r;
  assign out_num   = num3_r;
  assign out_neg   = neg3_r;
  assign out_dvs   = lt3_r;
endmodule
`default_nettype wire

[rtl/rcpm_div.sv]
// Pipelined restoring divider giving a twelve-bit quotient and an overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module rcpm_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire rcpm_pkg::side_t        in_side,
  input  wire logic [rcpm_pkg::NUM_W-1:0] in_num,
  input  wire logic                   in_neg,
  input  wire logic [rcpm_pkg::DVS_W-1:0] in_dvs,
  output logic                        out_valid,
  output rcpm_pkg::side_t             out_side,
  output logic [rcpm_pkg::DIV_STEPS-1:0] out_quo,
  output logic                        out_ovf,
  output logic                        out_neg,
  output logic                        out_zero_dvs
);
  import rcpm_pkg::*;

  localparam int HI_W = NUM_W - DIV_STEPS;

  logic                 v_r   [0:DIV_STEPS];
  side_t                side_r[0:DIV_STEPS];
  logic [DVS_W-1:0]     rem_r [0:DIV_STEPS];
  logic [DVS_W-1:0]     dvs_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] low_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [0:DIV_STEPS];
  logic                 ovf_r [0:DIV_STEPS];
  logic                 neg_r [0:DIV_STEPS];
  logic [HI_W-1:0]      hi;
  logic                 ovf0;

  assign hi   = in_num[NUM_W-1:DIV_STEPS];
  assign ovf0 = hi >= HI_W'(in_dvs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= DIV_STEPS; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    rem_r[0]  <= ovf0 ? '0 : hi[DVS_W-1:0];
    dvs_r[0]  <= in_dvs;
    low_r[0]  <= in_num[DIV_STEPS-1:0];
    quo_r[0]  <= '0;
    ovf_r[0]  <= ovf0;
    neg_r[0]  <= in_neg;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DVS_W:0] trial;
    logic           ge;
    assign trial = {rem_r[k-1], low_r[k-1][DIV_STEPS-1]};
    assign ge    = trial >= {1'b0, dvs_r[k-1]};
    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
      rem_r[k]  <= ge ? DVS_W'(trial - {1'b0, dvs_r[k-1]}) : trial[DVS_W-1:0];
      dvs_r[k]  <= dvs_r[k-1];
      low_r[k]  <= {low_r[k-1][DIV_STEPS-2:0], 1'b0};
      quo_r[k]  <= {quo_r[k-1][DIV_STEPS-2:0], ge};
      ovf_r[k]  <= ovf_r[k-1];
      neg_r[k]  <= neg_r[k-1];
    end
  end

  assign out_valid    = v_r[DIV_STEPS];
  assign out_side     = side_r[DIV_STEPS];
  assign out_quo      = quo_r[DIV_STEPS];
  assign out_ovf      = ovf_r[DIV_STEPS];
  assign out_neg      = neg_r[DIV_STEPS];
  assign out_zero_dvs = (dvs_r[DIV_STEPS] == '0);
endmodule
`default_nettype wire

[rtl/rcpm_back.sv]
// Back stages: texture row clamp, texel offset and the result register.
`timescale 1ns / 1ps
`default_nettype none
module rcpm_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire rcpm_pkg::side_t        in_side,
  input  wire logic [rcpm_pkg::DIV_STEPS-1:0] in_quo,
  input  wire logic                   in_ovf,
  input  wire logic                   in_neg,
  input  wire logic                   in_zero_dvs,
  input  wire rcpm_pkg::cfg_t         cfg,
  output logic                        out_valid,
  output rcpm_pkg::out_t              out_data
);
  import rcpm_pkg::*;

  logic        va_r, vb_r;
  side_t       sidea_r;
  logic [11:0] trow_r, trow_nxt, lim;
  logic        cl_r, cl_nxt;
  out_t        res_r, res_nxt;

  always_comb begin
    if (cfg.texture_height == 13'd0) lim = 12'd0;
    else if (cfg.texture_height > 13'd4096) lim = 12'd4095;
    else lim = 12'(cfg.texture_height - 13'd1);
    trow_nxt = 12'd0;
    cl_nxt   = 1'b0;
    if (in_side.kind != KIND_TEXEL || in_zero_dvs) begin
      trow_nxt = 12'd0;
    end else if (in_neg) begin
      cl_nxt = in_ovf || (in_quo != '0);
    end else if (in_ovf || in_quo > lim) begin
      trow_nxt = lim;
      cl_nxt   = 1'b1;
    end else begin
      trow_nxt = in_quo;
    end
  end

  always_comb begin
    res_nxt.pixel_kind   = sidea_r.kind;
    res_nxt.dest_offset  = sidea_r.dest;
    res_nxt.fill_color   = sidea_r.fill;
    res_nxt.texture_row  = trow_r;
    res_nxt.row_clamped  = cl_r;
    res_nxt.texel_offset = '0;
    if (sidea_r.kind == KIND_TEXEL) begin
      res_nxt.texel_offset = 26'(trow_r * cfg.texture_stride +
                                 sidea_r.tcol * cfg.texture_bpp[5:3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    sidea_r <= in_side;
    trow_r  <= trow_nxt;
    cl_r    <= cl_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = vb_r;
  assign out_data  = res_r;
endmodule
`default_nettype wire

[rtl/raycast_column_pixel_mapper_top.sv]
// Top level of the raycaster column pixel mapper with its register file.
// Throughput: one word per cycle; busy stays low, set by a fully pipelined path
// whose longest part is the restoring divider, twelve step stages after its input register.
// Reset: synchronous active-low rst_n clears the pipeline valid bits and
// loads the register defaults; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module raycast_column_pixel_mapper_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire rcpm_pkg::in_t                     in_data,
  output logic                                   out_valid,
  output rcpm_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rcpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rcpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rcpm_pkg::*;

  cfg_t             cfg_r;
  logic             f_valid, d_valid;
  side_t            f_side, d_side;
  logic [NUM_W-1:0] f_num;
  logic             f_neg, d_neg;
  logic [DVS_W-1:0] f_dvs;
  logic [DIV_STEPS-1:0] d_quo;
  logic             d_ovf, d_zero;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_height   <= 12'd480;
      cfg_r.frame_stride   <= 15'd2560;
      cfg_r.frame_bpp      <= 6'd32;
      cfg_r.texture_stride <= 15'd256;
      cfg_r.texture_height <= 13'd64;
      cfg_r.texture_bpp    <= 6'd32;
      cfg_r.ceiling_color  <= 24'd0;
      cfg_r.floor_color    <= 24'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_HEIGHT:   cfg_r.frame_height   <= cfg_data[11:0];
        REG_FRAME_STRIDE:   cfg_r.frame_stride   <= cfg_data[14:0];
        REG_FRAME_BPP:      cfg_r.frame_bpp      <= cfg_data[5:0];
        REG_TEXTURE_STRIDE: cfg_r.texture_stride <= cfg_data[14:0];
        REG_TEXTURE_HEIGHT: cfg_r.texture_height <= cfg_data[12:0];
        REG_TEXTURE_BPP:    cfg_r.texture_bpp    <= cfg_data[5:0];
        REG_CEILING_COLOR:  cfg_r.ceiling_color  <= cfg_data;
        REG_FLOOR_COLOR:    cfg_r.floor_color    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcpm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_item(in_data),
    .cfg(cfg_r), .out_valid(f_valid), .out_side(f_side), .out_num(f_num),
    .out_neg(f_neg), .out_dvs(f_dvs)
  );

  rcpm_div u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_side(f_side),
    .in_num(f_num), .in_neg(f_neg), .in_dvs(f_dvs), .out_valid(d_valid),
    .out_side(d_side), .out_quo(d_quo), .out_ovf(d_ovf), .out_neg(d_neg),
    .out_zero_dvs(d_zero)
  );

  rcpm_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(d_valid), .in_side(d_side),
    .in_quo(d_quo), .in_ovf(d_ovf), .in_neg(d_neg), .in_zero_dvs(d_zero),
    .cfg(cfg_r), .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire
